// ===== src/mfmd_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// mfmd_pkg
// Shared types and constants of the length-prefixed message deframer.
// ============================================================================
package mfmd_pkg;

   localparam int COUNT_BITS_DEFAULT  = 16;
   localparam int LENGTH_BITS_DEFAULT = 24;

   localparam int BYTE_BITS        = 8;
   localparam int FRAME_NUM_BITS   = 16;
   localparam int MAX_FRAMES_BITS  = 16;
   localparam int MAX_LENGTH_BITS  = 24;
   localparam int HEADER_BITS      = 32;
   localparam int SHIFT_BITS       = HEADER_BITS - BYTE_BITS;
   localparam int ERROR_BITS       = 2;
   localparam int CSR_INDEX_BITS   = 2;
   localparam int CSR_DATA_BITS    = 24;
   localparam int QUEUE_DEPTH      = 2;

   localparam logic [MAX_FRAMES_BITS-1:0] MAX_FRAMES_RESET = 16'd1024;
   localparam logic [MAX_LENGTH_BITS-1:0] MAX_LENGTH_RESET = 24'd65536;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_FRAMES       = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_FRAME_LENGTH = 2'd1;

   typedef enum logic [1:0] {
      PH_COUNT   = 2'd0,
      PH_LENGTH  = 2'd1,
      PH_CONTENT = 2'd2,
      PH_HALT    = 2'd3
   } phase_type;

   typedef enum logic [ERROR_BITS-1:0] {
      ERR_NONE   = 2'd0,
      ERR_COUNT  = 2'd1,
      ERR_LENGTH = 2'd2,
      ERR_DROP   = 2'd3
   } error_type;

   // What one accepted byte turned out to be.
   typedef enum logic [2:0] {
      K_IDLE        = 3'd0,
      K_CONTENT     = 3'd1,
      K_EMPTY_FRAME = 3'd2,
      K_ZERO_MSG    = 3'd3,
      K_ERR_COUNT   = 3'd4,
      K_ERR_LENGTH  = 3'd5,
      K_DROP        = 3'd6
   } kind_type;

   typedef struct packed {
      kind_type                  kind;
      logic [BYTE_BITS-1:0]      data_byte;
      logic [FRAME_NUM_BITS-1:0] frame_number;
      logic                      last_byte;
      logic                      last_frame;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } slot_type;

endpackage

// ===== src/mfmd_if.sv =====
`timescale 1ns / 1ps
// ============================================================================
// mfmd interfaces
// Valid/ready channels for received bytes, results and register writes.
// ============================================================================
interface mfmd_req_if;
   logic                          valid;
   logic                          ready;
   logic [mfmd_pkg::BYTE_BITS-1:0] data_byte;
   logic                          clear;

   modport source (output valid, output data_byte, output clear, input ready);
   modport sink   (input valid, input data_byte, input clear, output ready);
endinterface

interface mfmd_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [mfmd_pkg::BYTE_BITS-1:0]      content_byte;
   logic                               content_valid;
   logic [mfmd_pkg::FRAME_NUM_BITS-1:0] frame_number;
   logic                               frame_end;
   logic                               message_end;
   logic [mfmd_pkg::ERROR_BITS-1:0]     error_code;

   modport source (output valid, output content_byte, output content_valid,
                   output frame_number, output frame_end, output message_end,
                   output error_code, input ready);
   modport sink   (input valid, input content_byte, input content_valid,
                   input frame_number, input frame_end, input message_end,
                   input error_code, output ready);
endinterface

interface mfmd_csr_if;
   logic                               valid;
   logic                               ready;
   logic [mfmd_pkg::CSR_INDEX_BITS-1:0] index;
   logic [mfmd_pkg::CSR_DATA_BITS-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/mfmd_parser.sv =====
`timescale 1ns / 1ps
// ============================================================================
// mfmd_parser
// Front end: accepts one byte per cycle while the queue has room, tracks headers and frames, and
// classifies each byte into a queue entry. Holds the limit registers.
// ============================================================================
module mfmd_parser #(
   parameter int COUNT_BITS  = mfmd_pkg::COUNT_BITS_DEFAULT,
   parameter int LENGTH_BITS = mfmd_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   mfmd_req_if.sink          req,
   mfmd_csr_if.sink          csr,
   input  logic              q_ready,
   output mfmd_pkg::slot_type push
);

   localparam int HB = mfmd_pkg::HEADER_BITS;

   mfmd_pkg::phase_type                        phase_ff, phase_in;
   logic [mfmd_pkg::SHIFT_BITS-1:0]            header_shift_ff, header_shift_in;
   logic [1:0]                                 header_seen_ff, header_seen_in;
   logic [COUNT_BITS-1:0]                      frames_left_ff, frames_left_in;
   logic [mfmd_pkg::FRAME_NUM_BITS-1:0]        frame_counter_ff, frame_counter_in;
   logic [LENGTH_BITS-1:0]                     bytes_left_ff, bytes_left_in;
   logic [mfmd_pkg::MAX_FRAMES_BITS-1:0]       max_frames_ff;
   logic [mfmd_pkg::MAX_LENGTH_BITS-1:0]       max_length_ff;

   logic                  accept;
   logic [HB-1:0]         value_w;
   logic                  header_last;
   logic                  value_zero;
   logic                  count_over;
   logic                  length_over;
   logic [COUNT_BITS-1:0] frames_dec;
   logic                  frames_done;
   logic [LENGTH_BITS-1:0] bytes_dec;
   logic                  bytes_done;

   assign req.ready = q_ready;
   assign accept    = req.valid && q_ready;
   assign csr.ready = 1'b1;

   assign value_w     = {header_shift_ff, req.data_byte};
   assign header_last = (header_seen_ff == 2'd3);
   assign value_zero  = (value_w == '0);
   // A value that does not fit in the counter is over its limit as well.
   assign count_over  = (value_w > HB'(max_frames_ff)) || ((value_w >> COUNT_BITS) != '0);
   assign length_over = (value_w > HB'(max_length_ff)) || ((value_w >> LENGTH_BITS) != '0);
   assign frames_dec  = frames_left_ff - COUNT_BITS'(1);
   assign frames_done = (frames_dec == '0);
   assign bytes_dec   = bytes_left_ff - LENGTH_BITS'(1);
   assign bytes_done  = (bytes_dec == '0);

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         if (req.clear) begin
            phase_in = mfmd_pkg::PH_COUNT;
         end else begin
            unique case (phase_ff)
               mfmd_pkg::PH_COUNT: begin
                  if (header_last) begin
                     if (count_over)      phase_in = mfmd_pkg::PH_HALT;
                     else if (!value_zero) phase_in = mfmd_pkg::PH_LENGTH;
                  end
               end
               mfmd_pkg::PH_LENGTH: begin
                  if (header_last) begin
                     if (length_over)     phase_in = mfmd_pkg::PH_HALT;
                     else if (!value_zero) phase_in = mfmd_pkg::PH_CONTENT;
                     else if (frames_done) phase_in = mfmd_pkg::PH_COUNT;
                  end
               end
               mfmd_pkg::PH_CONTENT: begin
                  if (bytes_done) begin
                     phase_in = frames_done ? mfmd_pkg::PH_COUNT : mfmd_pkg::PH_LENGTH;
                  end
               end
               mfmd_pkg::PH_HALT: phase_in = mfmd_pkg::PH_HALT;
               default:           phase_in = mfmd_pkg::PH_COUNT;
            endcase
         end
      end
   end

   // Counters and the classified entry.
   always_comb begin
      header_shift_in  = header_shift_ff;
      header_seen_in   = header_seen_ff;
      frames_left_in   = frames_left_ff;
      frame_counter_in = frame_counter_ff;
      bytes_left_in    = bytes_left_ff;
      push.valid             = accept;
      push.entry.kind        = mfmd_pkg::K_IDLE;
      push.entry.data_byte   = req.data_byte;
      push.entry.frame_number = frame_counter_ff;
      push.entry.last_byte   = 1'b0;
      push.entry.last_frame  = frames_done;
      if (accept) begin
         if (req.clear) begin
            header_shift_in  = '0;
            header_seen_in   = '0;
            frames_left_in   = '0;
            frame_counter_in = '0;
            bytes_left_in    = '0;
         end else begin
            case (phase_ff) inside
               mfmd_pkg::PH_COUNT, mfmd_pkg::PH_LENGTH: begin
                  if (!header_last) begin
                     header_shift_in = {header_shift_ff[mfmd_pkg::SHIFT_BITS-9:0],
                                        req.data_byte};
                     header_seen_in  = header_seen_ff + 2'd1;
                  end else begin
                     header_shift_in = '0;
                     header_seen_in  = '0;
                     if (phase_ff == mfmd_pkg::PH_COUNT) begin
                        if (count_over) begin
                           push.entry.kind = mfmd_pkg::K_ERR_COUNT;
                        end else if (value_zero) begin
                           push.entry.kind = mfmd_pkg::K_ZERO_MSG;
                        end else begin
                           frames_left_in   = value_w[COUNT_BITS-1:0];
                           frame_counter_in = '0;
                        end
                     end else begin
                        if (length_over) begin
                           push.entry.kind = mfmd_pkg::K_ERR_LENGTH;
                        end else if (value_zero) begin
                           push.entry.kind = mfmd_pkg::K_EMPTY_FRAME;
                           frames_left_in  = frames_dec;
                           frame_counter_in = frames_done ? '0 : frame_counter_ff + 16'd1;
                        end else begin
                           bytes_left_in = value_w[LENGTH_BITS-1:0];
                        end
                     end
                  end
               end
               mfmd_pkg::PH_CONTENT: begin
                  push.entry.kind      = mfmd_pkg::K_CONTENT;
                  push.entry.last_byte = bytes_done;
                  bytes_left_in        = bytes_dec;
                  if (bytes_done) begin
                     frames_left_in   = frames_dec;
                     frame_counter_in = frames_done ? '0 : frame_counter_ff + 16'd1;
                  end
               end
               default: push.entry.kind = mfmd_pkg::K_DROP;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= mfmd_pkg::PH_COUNT;
         header_shift_ff  <= '0;
         header_seen_ff   <= '0;
         frames_left_ff   <= '0;
         frame_counter_ff <= '0;
         bytes_left_ff    <= '0;
      end else begin
         phase_ff         <= phase_in;
         header_shift_ff  <= header_shift_in;
         header_seen_ff   <= header_seen_in;
         frames_left_ff   <= frames_left_in;
         frame_counter_ff <= frame_counter_in;
         bytes_left_ff    <= bytes_left_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_frames_ff <= mfmd_pkg::MAX_FRAMES_RESET;
         max_length_ff <= mfmd_pkg::MAX_LENGTH_RESET;
      end else if (csr.valid) begin
         unique case (csr.index)
            mfmd_pkg::CSR_MAX_FRAMES:
               max_frames_ff <= csr.data[mfmd_pkg::MAX_FRAMES_BITS-1:0];
            mfmd_pkg::CSR_MAX_FRAME_LENGTH:
               max_length_ff <= csr.data[mfmd_pkg::MAX_LENGTH_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Header bytes are only collected in the two header phases.
   a_seen_in_header: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == mfmd_pkg::PH_CONTENT || phase_ff == mfmd_pkg::PH_HALT)
      |-> header_seen_ff == 2'd0)
      else $error("header byte count left over outside a header");

   a_content_has_bytes: assert property (@(posedge clock) disable iff (reset)
      phase_ff == mfmd_pkg::PH_CONTENT |-> bytes_left_ff != '0)
      else $error("content phase with no bytes left");

   a_frames_pending: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == mfmd_pkg::PH_LENGTH || phase_ff == mfmd_pkg::PH_CONTENT)
      |-> frames_left_ff != '0)
      else $error("frame phase with no frames left");

endmodule

// ===== src/mfmd_queue.sv =====
`timescale 1ns / 1ps
// ============================================================================
// mfmd_queue
// Short queue of classified entries between the parser and the output stage.
// ============================================================================
module mfmd_queue (
   input  logic               clock,
   input  logic               reset,
   input  mfmd_pkg::slot_type push,
   output logic               q_ready,
   output mfmd_pkg::slot_type head,
   input  logic               pop
);

   localparam int PTR_BITS = $clog2(mfmd_pkg::QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(mfmd_pkg::QUEUE_DEPTH + 1);

   mfmd_pkg::entry_type  entries_ff [mfmd_pkg::QUEUE_DEPTH];
   logic [PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic                 do_pop;

   assign q_ready    = (count_ff != CNT_BITS'(mfmd_pkg::QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.entry = entries_ff[rd_ptr_ff];
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(mfmd_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_ff + PTR_BITS'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(mfmd_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_ff + PTR_BITS'(1);
      end
      if (push.valid && !do_pop) count_in = count_ff + CNT_BITS'(1);
      else if (!push.valid && do_pop) count_in = count_ff - CNT_BITS'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) entries_ff[wr_ptr_ff] <= push.entry;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (count_ff == CNT_BITS'(mfmd_pkg::QUEUE_DEPTH) && !do_pop) |=> !$past(push.valid)
      || $past(q_ready))
      else $error("transaction pushed into a full queue");

endmodule

// ===== src/mfmd_emit.sv =====
`timescale 1ns / 1ps
// ============================================================================
// mfmd_emit
// Back end: expands queue entries into result fields in an output register.
// ============================================================================
module mfmd_emit (
   input  logic               clock,
   input  logic               reset,
   input  mfmd_pkg::slot_type head,
   output logic               pop,
   mfmd_rsp_if.source         rsp
);

   logic                                out_valid_ff;
   logic [mfmd_pkg::BYTE_BITS-1:0]      content_byte_ff, content_byte_in;
   logic                                content_valid_ff, content_valid_in;
   logic [mfmd_pkg::FRAME_NUM_BITS-1:0] frame_number_ff, frame_number_in;
   logic                                frame_end_ff, frame_end_in;
   logic                                message_end_ff, message_end_in;
   mfmd_pkg::error_type                 error_ff, error_in;

   assign pop = head.valid && (!out_valid_ff || rsp.ready);

   always_comb begin
      content_byte_in  = '0;
      content_valid_in = 1'b0;
      frame_number_in  = '0;
      frame_end_in     = 1'b0;
      message_end_in   = 1'b0;
      error_in         = mfmd_pkg::ERR_NONE;
      unique case (head.entry.kind)
         mfmd_pkg::K_CONTENT: begin
            content_byte_in  = head.entry.data_byte;
            content_valid_in = 1'b1;
            frame_number_in  = head.entry.frame_number;
            frame_end_in     = head.entry.last_byte;
            message_end_in   = head.entry.last_byte && head.entry.last_frame;
         end
         mfmd_pkg::K_EMPTY_FRAME: begin
            frame_number_in = head.entry.frame_number;
            frame_end_in    = 1'b1;
            message_end_in  = head.entry.last_frame;
         end
         mfmd_pkg::K_ZERO_MSG:   message_end_in = 1'b1;
         mfmd_pkg::K_ERR_COUNT:  error_in = mfmd_pkg::ERR_COUNT;
         mfmd_pkg::K_ERR_LENGTH: error_in = mfmd_pkg::ERR_LENGTH;
         mfmd_pkg::K_DROP:       error_in = mfmd_pkg::ERR_DROP;
         mfmd_pkg::K_IDLE:       ;
         default:                ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (pop) begin
         out_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         content_byte_ff  <= content_byte_in;
         content_valid_ff <= content_valid_in;
         frame_number_ff  <= frame_number_in;
         frame_end_ff     <= frame_end_in;
         message_end_ff   <= message_end_in;
         error_ff         <= error_in;
      end
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.content_byte  = content_byte_ff;
   assign rsp.content_valid = content_valid_ff;
   assign rsp.frame_number  = frame_number_ff;
   assign rsp.frame_end     = frame_end_ff;
   assign rsp.message_end   = message_end_ff;
   assign rsp.error_code    = error_ff;

   a_error_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.error_code != mfmd_pkg::ERR_NONE)
      |-> !rsp.content_valid && !rsp.frame_end && !rsp.message_end)
      else $error("error result carries frame marks");

endmodule

// ===== src/multi_frame_message_deframer_core.sv =====
`timescale 1ns / 1ps
// ============================================================================
// multi_frame_message_deframer_core
// Length-prefixed message deframer: count header, frames of length + content.
// ============================================================================
// A result passes through a queue entry and then the output register before
// it is valid on the result channel.
// Throughput: one byte per cycle when neither side stalls; the parser updates
// its header and frame counters as each byte is accepted, and a two-entry queue
// decouples it from the output register, so either side may stall without a bubble.
// Reset: synchronous; restores the limit registers and expects a count header.
module multi_frame_message_deframer_core #(
   parameter int COUNT_BITS  = mfmd_pkg::COUNT_BITS_DEFAULT,
   parameter int LENGTH_BITS = mfmd_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   mfmd_req_if.sink   req_ch,
   mfmd_rsp_if.source rsp_ch,
   mfmd_csr_if.sink   csr_ch
);

   mfmd_pkg::slot_type push;
   mfmd_pkg::slot_type head;
   logic               q_ready;
   logic               pop;

   mfmd_parser #(
      .COUNT_BITS  (COUNT_BITS),
      .LENGTH_BITS (LENGTH_BITS)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .csr     (csr_ch),
      .q_ready (q_ready),
      .push    (push)
   );

   mfmd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .q_ready (q_ready),
      .head    (head),
      .pop     (pop)
   );

   mfmd_emit u_emit (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .pop   (pop),
      .rsp   (rsp_ch)
   );

endmodule

// ===== verif/tb_multi_frame_message_deframer_core.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_multi_frame_message_deframer_core
// Self-checking testbench for the length-prefixed message deframer. It drives
// byte streams made mostly of well-formed messages, with some noise, clears
// and over-limit headers mixed in. A cycle-free model predicts one result per
// accepted byte, and each result transaction is checked field by field in
// order. Both channels pause at random, and the limit registers are changed
// between phases while the block is idle.
// ============================================================================
module tb_multi_frame_message_deframer_core;

   localparam logic [31:0] COUNT_LIMIT  =
      32'((64'd1 << mfmd_pkg::COUNT_BITS_DEFAULT) - 64'd1);
   localparam logic [31:0] LENGTH_LIMIT =
      32'((64'd1 << mfmd_pkg::LENGTH_BITS_DEFAULT) - 64'd1);
   localparam int     CYCLE_LIMIT  = 1000000;
   localparam int     SETTLE_CYCLES = 8;
   localparam int     RANDOM_PHASES = 6;
   localparam int     RANDOM_BYTES  = 1600;

   typedef struct packed {
      logic [mfmd_pkg::BYTE_BITS-1:0]      content_byte;
      logic                                content_valid;
      logic [mfmd_pkg::FRAME_NUM_BITS-1:0] frame_number;
      logic                                frame_end;
      logic                                message_end;
      mfmd_pkg::error_type                 error_code;
   } frame_result_type;

   logic clock = 1'b0;
   logic reset;

   mfmd_req_if req_ch ();
   mfmd_rsp_if rsp_ch ();
   mfmd_csr_if csr_ch ();

   multi_frame_message_deframer_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #2 clock = ~clock;

   // Parser state of the predictor and its copy of the limit registers.
   mfmd_pkg::phase_type                  parse_phase;
   logic [mfmd_pkg::SHIFT_BITS-1:0]      hdr_shift;
   logic [1:0]                           hdr_seen;
   logic [15:0]                          frames_left;
   logic [mfmd_pkg::FRAME_NUM_BITS-1:0]  frame_idx;
   logic [23:0]                          bytes_left;
   logic [mfmd_pkg::MAX_FRAMES_BITS-1:0] lim_frames = mfmd_pkg::MAX_FRAMES_RESET;
   logic [mfmd_pkg::MAX_LENGTH_BITS-1:0] lim_length = mfmd_pkg::MAX_LENGTH_RESET;

   frame_result_type pending_results[$];
   int            mismatch_count = 0;
   int            bytes_sent = 0;
   int            cycle_count = 0;
   int            rsp_hold = 0;
   bit            idle_on = 1'b0;

   function automatic void restart_parser();
      parse_phase = mfmd_pkg::PH_COUNT;
      hdr_shift   = '0;
      hdr_seen    = '0;
      frames_left = '0;
      frame_idx   = '0;
      bytes_left  = '0;
   endfunction

   initial restart_parser();

   function automatic void close_frame(inout frame_result_type r);
      r.frame_number = frame_idx;
      r.frame_end    = 1'b1;
      frames_left    = frames_left - 16'd1;
      if (frames_left == '0) begin
         r.message_end = 1'b1;
         parse_phase   = mfmd_pkg::PH_COUNT;
         frame_idx     = '0;
      end else begin
         parse_phase = mfmd_pkg::PH_LENGTH;
         frame_idx   = frame_idx + 16'd1;
      end
   endfunction

   function automatic frame_result_type deframe_byte(input logic [7:0] b, input logic clr);
      frame_result_type r;
      logic [31:0]   value;
      r = '0;
      if (clr) begin
         restart_parser();
         return r;
      end
      case (parse_phase) inside
         mfmd_pkg::PH_COUNT, mfmd_pkg::PH_LENGTH: begin
            if (hdr_seen != 2'd3) begin
               hdr_shift = {hdr_shift[15:0], b};
               hdr_seen  = hdr_seen + 2'd1;
            end else begin
               value     = {hdr_shift, b};
               hdr_shift = '0;
               hdr_seen  = '0;
               if (parse_phase == mfmd_pkg::PH_COUNT) begin
                  if (value > 32'(lim_frames) || value > COUNT_LIMIT) begin
                     r.error_code = mfmd_pkg::ERR_COUNT;
                     parse_phase  = mfmd_pkg::PH_HALT;
                  end else if (value == '0) begin
                     r.message_end = 1'b1;
                  end else begin
                     frames_left = value[15:0];
                     frame_idx   = '0;
                     parse_phase = mfmd_pkg::PH_LENGTH;
                  end
               end else begin
                  if (value > 32'(lim_length) || value > LENGTH_LIMIT) begin
                     r.error_code = mfmd_pkg::ERR_LENGTH;
                     parse_phase  = mfmd_pkg::PH_HALT;
                  end else if (value == '0) begin
                     close_frame(r);
                  end else begin
                     bytes_left  = value[23:0];
                     parse_phase = mfmd_pkg::PH_CONTENT;
                  end
               end
            end
         end
         mfmd_pkg::PH_CONTENT: begin
            r.content_byte  = b;
            r.content_valid = 1'b1;
            r.frame_number  = frame_idx;
            bytes_left      = bytes_left - 24'd1;
            if (bytes_left == '0) close_frame(r);
         end
         default: r.error_code = mfmd_pkg::ERR_DROP;
      endcase
      return r;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      // Printing is capped so a broken build cannot flood the log.
      if (mismatch_count < 100)
         $display("MISMATCH %s: got %0h, expected %0h (t=%0t)", what, got, want, $realtime);
      mismatch_count++;
   endtask

   task automatic compare_field(input string what, input longint got, input longint want);
      if (got != want) report_mismatch(what, got, want);
   endtask

   // Response checker: every result transaction is matched against the oldest prediction.
   always @(posedge clock) begin
      frame_result_type want;
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result with nothing pending",
                            longint'(rsp_ch.content_byte), longint'(0));
         end else begin
            want = pending_results.pop_front();
            compare_field("content_byte", longint'(rsp_ch.content_byte),
                          longint'(want.content_byte));
            compare_field("content_valid", longint'(rsp_ch.content_valid),
                          longint'(want.content_valid));
            compare_field("frame_number", longint'(rsp_ch.frame_number),
                          longint'(want.frame_number));
            compare_field("frame_end", longint'(rsp_ch.frame_end),
                          longint'(want.frame_end));
            compare_field("message_end", longint'(rsp_ch.message_end),
                          longint'(want.message_end));
            compare_field("error_code", longint'(rsp_ch.error_code),
                          longint'(want.error_code));
         end
      end
   end

   function automatic int pick_gap();
      if ($urandom_range(9, 0) < 8) return $urandom_range(3, 1);
      return $urandom_range(30, 8);
   endfunction

   // Result-side back-pressure.
   always @(negedge clock) begin
      if (rsp_hold != 0) begin
         rsp_ch.ready = 1'b0;
         rsp_hold--;
      end else begin
         rsp_ch.ready = 1'b1;
         if (idle_on && $urandom_range(9, 0) == 0) rsp_hold = pick_gap();
      end
   end

   function automatic int unsigned bounded(input int unsigned limit, input int unsigned cap);
      return (limit < cap) ? limit : cap;
   endfunction

   task automatic drive_byte(input logic [7:0] b, input logic clr);
      int gap;
      gap = 0;
      if (idle_on && $urandom_range(3, 0) == 0) gap = pick_gap();
      if (gap != 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid     = 1'b1;
      req_ch.data_byte = b;
      req_ch.clear     = clr;
      do @(posedge clock); while (!req_ch.ready);
      pending_results.push_back(deframe_byte(b, clr));
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_clear();
      drive_byte(8'($urandom_range(255, 0)), 1'b1);
   endtask

   task automatic send_header(input logic [31:0] value);
      for (int i = 3; i >= 0; i--) drive_byte(value[8*i +: 8], 1'b0);
   endtask

   task automatic drive_frame(input int unsigned len);
      send_header(len);
      repeat (len) drive_byte(8'($urandom_range(255, 0)), 1'b0);
   endtask

   task automatic send_message(input int unsigned count);
      int unsigned len;
      send_header(count);
      for (int unsigned i = 0; i < count; i++) begin
         if ($urandom_range(9, 0) == 0) len = $urandom_range(bounded(32'(lim_length), 48), 0);
         else len = $urandom_range(bounded(32'(lim_length), 12), 0);
         drive_frame(len);
      end
   endtask

   // Bytes dropped while halted, then the clear that leaves the halted state.
   task automatic drop_and_clear();
      repeat ($urandom_range(3, 0)) drive_byte(8'($urandom_range(255, 0)), 1'b0);
      send_clear();
   endtask

   task automatic drain_results();
      req_ch.valid = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [mfmd_pkg::CSR_INDEX_BITS-1:0] idx,
                            input logic [mfmd_pkg::CSR_DATA_BITS-1:0] data);
      csr_ch.valid = 1'b1;
      csr_ch.index = idx;
      csr_ch.data  = data;
      do @(posedge clock); while (!csr_ch.ready);
      if (idx == mfmd_pkg::CSR_MAX_FRAMES)
         lim_frames = data[mfmd_pkg::MAX_FRAMES_BITS-1:0];
      else if (idx == mfmd_pkg::CSR_MAX_FRAME_LENGTH)
         lim_length = data[mfmd_pkg::MAX_LENGTH_BITS-1:0];
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   task automatic set_limits(input logic [15:0] frames, input logic [23:0] length);
      drain_results();
      if ($urandom_range(1, 0)) begin
         write_reg(mfmd_pkg::CSR_MAX_FRAMES, {8'h00, frames});
         write_reg(mfmd_pkg::CSR_MAX_FRAME_LENGTH, length);
      end else begin
         write_reg(mfmd_pkg::CSR_MAX_FRAME_LENGTH, length);
         write_reg(mfmd_pkg::CSR_MAX_FRAMES, {8'h00, frames});
      end
   endtask

   // Reset limits: zero-frame message, empty frame, last frame of one byte,
   // count over limit with drops, clear out of halt, length over limit.
   task automatic test_directed_cases();
      idle_on = 1'b0;
      send_header(32'h0000_0000);
      send_header(32'h0000_0002);
      send_header(32'h0000_0000);
      send_header(32'h0000_0001);
      drive_byte(8'hFF, 1'b0);
      send_header(32'hFFFF_FFFF);
      drive_byte(8'h00, 1'b0);
      drive_byte(8'hFF, 1'b1);
      send_header(32'h0000_0001);
      send_header(32'h0001_0001);
      send_clear();
   endtask

   // Limits at their extremes; each boundary but the zero length limit is hit from both sides.
   task automatic test_limit_registers();
      idle_on = 1'b1;
      set_limits(16'd0, 24'd0);
      send_header(32'd1);
      drop_and_clear();
      send_header(32'd0);

      set_limits(16'd1, 24'd1);
      send_message(1);
      send_header(32'd1);
      send_header(32'd2);
      drop_and_clear();
      send_header(32'd2);
      drop_and_clear();

      set_limits(16'hFFFF, 24'hFF_FFFF);
      // Values wider than the counters must fail even at the largest limits.
      send_header(32'h0001_0000);
      drop_and_clear();
      send_header(32'h0000_FFFF);
      send_header(32'h0100_0000);
      drop_and_clear();
      send_header(32'h0000_FFFF);
      send_header(32'h00FF_FFFF);
      repeat (3) drive_byte(8'($urandom_range(255, 0)), 1'b0);
      send_clear();
   endtask

   task automatic test_random_traffic();
      int          stop_at;
      int unsigned pick;
      int unsigned count;
      logic [15:0] frames;
      logic [23:0] length;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case ($urandom_range(4, 0))
            0:       frames = 16'd0;
            1:       frames = 16'hFFFF;
            2:       frames = 16'($urandom_range(4, 1));
            default: frames = 16'($urandom_range(65535, 1));
         endcase
         case ($urandom_range(4, 0))
            0:       length = 24'd0;
            1:       length = 24'hFF_FFFF;
            2:       length = 24'($urandom_range(3, 1));
            default: length = 24'($urandom_range(64, 4));
         endcase
         if (p == 0) begin
            frames = 16'hFFFF;
            length = 24'hFF_FFFF;
         end
         set_limits(frames, length);
         stop_at = bytes_sent + RANDOM_BYTES / RANDOM_PHASES;
         while (bytes_sent < stop_at) begin
            idle_on = ($urandom_range(4, 0) != 0);
            pick = $urandom_range(99, 0);
            if (pick < 72) begin
               if (pick < 6) count = $urandom_range(bounded(32'(lim_frames), 20), 0);
               else count = $urandom_range(bounded(32'(lim_frames), 4), 0);
               send_message(count);
            end else if (pick < 80) begin
               send_header($urandom_range(32'hFFFF_FFFF, 32'(lim_frames) + 32'd1));
               drop_and_clear();
            end else if (pick < 88) begin
               send_header($urandom_range(bounded(32'(lim_frames), 3) > 0 ?
                                          bounded(32'(lim_frames), 3) : 1, 1));
               send_header($urandom_range(32'hFFFF_FFFF, 32'(lim_length) + 32'd1));
               drop_and_clear();
            end else begin
               // Noise with clears at random points, then back in step.
               repeat ($urandom_range(10, 1))
                  drive_byte(8'($urandom_range(255, 0)), $urandom_range(4, 0) == 0);
               send_clear();
            end
         end
      end
   endtask

   initial begin
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.data_byte = '0;
      req_ch.clear     = 1'b0;
      rsp_ch.ready     = 1'b0;
      csr_ch.valid     = 1'b0;
      csr_ch.index     = mfmd_pkg::CSR_MAX_FRAMES;
      csr_ch.data      = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_cases();
      test_limit_registers();
      test_random_traffic();

      idle_on = 1'b0;
      drain_results();
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== multi_frame_message_deframer_core.f =====
src/mfmd_pkg.sv
src/mfmd_if.sv
src/mfmd_parser.sv
src/mfmd_queue.sv
src/mfmd_emit.sv
src/multi_frame_message_deframer_core.sv
verif/tb_multi_frame_message_deframer_core.sv
